@@ rtl/vmm_pkg.sv @@
// Shared types and constants for the vector-matrix multiply block.
// No dependencies; used by every module of the block except vmm_ram.
`timescale 1ns / 1ps

package vmm_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam int IN_W      = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 48;
    localparam int ROW_W     = 16;
    localparam int COLTOT_W  = 11;
    localparam int COLIDX_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_TOTAL = 2'd1;

    // Per-item classification made by the front end.
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } t_flags;

endpackage

@@ rtl/vmm_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`timescale 1ns / 1ps

module vmm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vmm_front.sv @@
// Front end: configuration registers, row/column tracking, product register.
// Depends on vmm_pkg.
`timescale 1ns / 1ps

module vmm_front #(
    parameter int MAX_COLUMNS = vmm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [vmm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vmm_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [vmm_pkg::IN_W-1:0]  i_vector_value,
    input  logic signed [vmm_pkg::IN_W-1:0]  i_matrix_value,
    output logic                             o_valid,
    input  logic                             i_full,
    output vmm_pkg::t_flags                  o_flags,
    output logic [$clog2(MAX_COLUMNS)-1:0]   o_col,
    output logic [vmm_pkg::PROD_W-1:0]       o_prod
);
    import vmm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ECW   = 17;

    logic [ROW_W-1:0]    r_row_total;
    logic [COLTOT_W-1:0] r_column_total;
    logic [ROW_W-1:0]    r_row_pos;
    logic [COL_W-1:0]    r_col_pos;

    logic                r_valid;
    t_flags              r_flags;
    logic [COL_W-1:0]    r_col;
    logic [PROD_W-1:0]   r_prod;

    logic [ECW-1:0]      eff_cols;
    logic [ECW-1:0]      cols_m1_w;
    logic [COL_W-1:0]    cols_m1;
    logic [ROW_W-1:0]    rows_m1;
    logic                last_col;
    logic                last_row;
    logic [COL_W-1:0]    col;
    logic signed [PROD_W-1:0] prod;
    logic                accept;
    logic                push;
    logic [ROW_W-1:0]    n_row_pos;
    logic [COL_W-1:0]    n_col_pos;

    always_comb begin
        eff_cols = (r_column_total == '0) ? ECW'(1) : ECW'(r_column_total);
        if (eff_cols > ECW'(MAX_COLUMNS)) begin
            eff_cols = ECW'(MAX_COLUMNS);
        end
        cols_m1_w = eff_cols - ECW'(1);
        cols_m1   = cols_m1_w[COL_W-1:0];
        rows_m1   = (r_row_total == '0) ? '0 : r_row_total - ROW_W'(1);
    end

    // A position left beyond a shrunken limit counts as the last one.
    assign last_col = (r_col_pos >= cols_m1);
    assign last_row = (r_row_pos >= rows_m1);
    assign col      = last_col ? cols_m1 : r_col_pos;
    assign prod     = i_vector_value * i_matrix_value;

    assign push       = r_valid && !i_full;
    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_row_pos = r_row_pos;
        n_col_pos = r_col_pos;
        if (last_col) begin
            n_col_pos = '0;
            n_row_pos = last_row ? '0 : r_row_pos + ROW_W'(1);
        end else begin
            n_col_pos = r_col_pos + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_total    <= ROW_W'(1);
            r_column_total <= COLTOT_W'(1);
            r_row_pos      <= '0;
            r_col_pos      <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROW_TOTAL:    r_row_total    <= i_cfg_data[ROW_W-1:0];
                    CFG_COLUMN_TOTAL: r_column_total <= i_cfg_data[COLTOT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_row_pos <= n_row_pos;
                r_col_pos <= n_col_pos;
                r_valid   <= 1'b1;
            end else if (push) begin
                r_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags.first_row <= (r_row_pos == '0);
            r_flags.last_row  <= last_row;
            r_flags.last_col  <= last_col;
            r_col             <= col;
            r_prod            <= prod;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_col   = r_col;
    assign o_prod  = r_prod;

endmodule

@@ rtl/vmm_queue.sv @@
// Small register FIFO between the front end and the accumulate stage.
// Depends on vmm_pkg for the default depth.
`timescale 1ns / 1ps

module vmm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vmm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nempty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_data   = r_slot[r_rptr];

    assign n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
    assign n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

@@ rtl/vmm_back.sv @@
// Accumulate stage: column accumulator RAM, read-modify-write with bypass,
// and the result output register. Depends on vmm_pkg and vmm_ram.
`timescale 1ns / 1ps

module vmm_back #(
    parameter int MAX_COLUMNS = vmm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_nempty,
    output logic                              o_q_pop,
    input  vmm_pkg::t_flags                   i_flags,
    input  logic [$clog2(MAX_COLUMNS)-1:0]    i_col,
    input  logic [vmm_pkg::PROD_W-1:0]        i_prod,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vmm_pkg::COLIDX_W-1:0]      o_column_index,
    output logic signed [vmm_pkg::SUM_W-1:0]  o_dot_value,
    output logic                              o_last_output
);
    import vmm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);

    logic              r_b_valid;
    t_flags            r_b_flags;
    logic [COL_W-1:0]  r_b_col;
    logic [PROD_W-1:0] r_b_prod;

    // Most recent accumulator write, forwarded over the RAM read.
    logic              r_last_valid;
    logic [COL_W-1:0]  r_last_col;
    logic [SUM_W-1:0]  r_last_sum;

    logic              r_out_valid;
    logic [COLIDX_W-1:0] r_out_col;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_last;

    logic [SUM_W-1:0]  rdata;
    logic [SUM_W-1:0]  acc;
    logic [SUM_W-1:0]  prod_ext;
    logic [SUM_W-1:0]  sum;
    logic [COL_W+COLIDX_W-1:0] col_ext;
    logic              out_free;
    logic              b_adv;
    logic              pop;

    assign out_free = !r_out_valid || !i_out_stall;
    assign b_adv    = r_b_valid && (!r_b_flags.last_row || out_free);
    assign pop      = i_q_nempty && (!r_b_valid || b_adv);
    assign o_q_pop  = pop;

    assign acc      = (r_last_valid && (r_last_col == r_b_col)) ? r_last_sum : rdata;
    assign prod_ext = {{(SUM_W-PROD_W){r_b_prod[PROD_W-1]}}, r_b_prod};
    assign sum      = r_b_flags.first_row ? prod_ext : acc + prod_ext;
    assign col_ext  = (COL_W+COLIDX_W)'(r_b_col);

    vmm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLUMNS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_col),
        .i_wdata (sum),
        .i_re    (pop),
        .i_raddr (i_col),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_last_valid <= 1'b1;
            end
            if (b_adv && r_b_flags.last_row) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_flags <= i_flags;
            r_b_col   <= i_col;
            r_b_prod  <= i_prod;
        end
        if (b_adv) begin
            r_last_col <= r_b_col;
            r_last_sum <= sum;
        end
        if (b_adv && r_b_flags.last_row) begin
            r_out_col  <= col_ext[COLIDX_W-1:0];
            r_out_sum  <= sum;
            r_out_last <= r_b_flags.last_col;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_index = r_out_col;
    assign o_dot_value    = r_out_sum;
    assign o_last_output  = r_out_last;

endmodule

@@ rtl/vector_matrix_multiply.sv @@
// Path of an item: front product register, queue, RAM read, then accumulate into
// the output register. Throughput: one item per cycle while i_out_stall is low;
// the accumulator RAM does one read and one write per cycle and the last write
// is forwarded, so equal columns never stall.
// Reset (i_rst_n low, synchronous): counters, queue and valids clear,
// row_total and column_total return to 1; accumulators need no clearing.
`timescale 1ns / 1ps

module vector_matrix_multiply #(
    parameter int MAX_COLUMNS = vmm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vmm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vmm_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [vmm_pkg::IN_W-1:0]   i_vector_value,
    input  logic signed [vmm_pkg::IN_W-1:0]   i_matrix_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vmm_pkg::COLIDX_W-1:0]      o_column_index,
    output logic signed [vmm_pkg::SUM_W-1:0]  o_dot_value,
    output logic                              o_last_output
);
    import vmm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int FL_W  = $bits(t_flags);
    localparam int Q_W   = FL_W + COL_W + PROD_W;

    logic              f_valid;
    t_flags            f_flags;
    logic [COL_W-1:0]  f_col;
    logic [PROD_W-1:0] f_prod;
    logic              q_full;
    logic              q_nempty;
    logic              q_pop;
    logic [Q_W-1:0]    q_in;
    logic [Q_W-1:0]    q_out;
    t_flags            q_flags;

    assign o_cfg_ready = 1'b1;

    vmm_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_vector_value (i_vector_value),
        .i_matrix_value (i_matrix_value),
        .o_valid        (f_valid),
        .i_full         (q_full),
        .o_flags        (f_flags),
        .o_col          (f_col),
        .o_prod         (f_prod)
    );

    assign q_in = {f_flags, f_col, f_prod};

    vmm_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid && !q_full),
        .i_data   (q_in),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_nempty (q_nempty),
        .o_data   (q_out)
    );

    assign q_flags = q_out[Q_W-1 -: FL_W];

    vmm_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nempty     (q_nempty),
        .o_q_pop        (q_pop),
        .i_flags        (q_flags),
        .i_col          (q_out[PROD_W +: COL_W]),
        .i_prod         (q_out[PROD_W-1:0]),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column_index (o_column_index),
        .o_dot_value    (o_dot_value),
        .o_last_output  (o_last_output)
    );

endmodule

@@ rtl/vmm_checker.sv @@
// Port-level checks for the vector-matrix multiply block, bound to the top level.
// Depends on vmm_pkg and vector_matrix_multiply.
`timescale 1ns / 1ps

module vmm_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [vmm_pkg::COLIDX_W-1:0]      o_column_index,
    input  logic signed [vmm_pkg::SUM_W-1:0]  o_dot_value,
    input  logic                              o_last_output
);

    logic        in_xfer;
    logic        out_xfer;
    logic [31:0] r_pending;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // Items transferred in but whose result (if any) has not yet left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_pending <= r_pending + 32'd1;
        end else if (out_xfer && !in_xfer && (r_pending != '0)) begin
            r_pending <= r_pending - 32'd1;
        end
    end

    a_reset_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_reset_in_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pending != '0))
        else $error("result without an earlier input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_dot_value) && $stable(o_column_index)
             && $stable(o_last_output)))
        else $error("stalled result changed");

endmodule

bind vector_matrix_multiply vmm_checker u_vmm_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for vector_matrix_multiply: streams matrix rows with random
// handshake gaps and compares every dot product against a local predictor.
// Depends on rtl/vmm_pkg.sv and rtl/vector_matrix_multiply.sv.
`timescale 1ns / 1ps

module tb_top;
    import vmm_pkg::*;

    localparam int MAX_COLS    = MAX_COLUMNS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_QUIET = 12;
    localparam int PRINT_CAP   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic signed [IN_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [IN_W-1:0] Q_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [IN_W-1:0] vec;
        logic signed [IN_W-1:0] mat;
    } t_mac_item;

    typedef struct packed {
        logic [COLIDX_W-1:0] column;
        logic [SUM_W-1:0]    dot;
        logic                last;
    } t_dot_result;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index    = '0;
    logic [CFG_DAT_W-1:0]        i_cfg_data     = '0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_stall;
    logic signed [IN_W-1:0]      i_vector_value = '0;
    logic signed [IN_W-1:0]      i_matrix_value = '0;
    logic                        o_out_valid;
    logic                        i_out_stall    = 1'b0;
    logic [COLIDX_W-1:0]         o_column_index;
    logic signed [SUM_W-1:0]     o_dot_value;
    logic                        o_last_output;

    vector_matrix_multiply u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_vector_value (i_vector_value),
        .i_matrix_value (i_matrix_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column_index (o_column_index),
        .o_dot_value    (o_dot_value),
        .o_last_output  (o_last_output)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [SUM_W-1:0]    col_acc [0:MAX_COLS-1];
    int unsigned         acc_row  = 0;
    int unsigned         acc_col  = 0;
    logic [ROW_W-1:0]    rows_reg = 16'd1;
    logic [COLTOT_W-1:0] cols_reg = 11'd1;

    t_mac_item   item_queue[$];
    t_dot_result dots_due[$];

    t_mac_item feed_item = '0;
    bit        feed_busy = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int items_accepted = 0;
    int dots_checked   = 0;
    int regs_written   = 0;
    int cycle_count    = 0;

    function automatic void accumulate_item(input logic signed [IN_W-1:0] a,
                                            input logic signed [IN_W-1:0] b);
        logic signed [PROD_W-1:0] prod;
        int unsigned              rows;
        int unsigned              cols;
        int unsigned              col;
        logic                     last_row;
        logic                     last_col;
        logic [SUM_W-1:0]         sum;
        t_dot_result              res;
        prod = a * b;
        rows = (rows_reg == 0) ? 1 : rows_reg;
        cols = (cols_reg == 0) ? 1 : cols_reg;
        if (cols > MAX_COLS)
            cols = MAX_COLS;
        // a position past the end (after a shrinking write) counts as the last one
        col      = (acc_col >= cols) ? cols - 1 : acc_col;
        last_col = (acc_col >= cols - 1);
        last_row = (acc_row >= rows - 1);
        if (acc_row == 0)
            sum = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        else
            sum = col_acc[col] + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        col_acc[col] = sum;
        if (last_row) begin
            res.column = col[COLIDX_W-1:0];
            res.dot    = sum;
            res.last   = last_col;
            dots_due.push_back(res);
        end
        if (last_col) begin
            acc_col = 0;
            acc_row = last_row ? 0 : ((acc_row + 1) & 16'hFFFF);
        end else begin
            acc_col++;
        end
    endfunction

    function automatic logic signed [IN_W-1:0] pick_q15();
        case ($urandom_range(9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] b);
        t_mac_item it;
        it.vec = a;
        it.mat = b;
        item_queue.push_back(it);
    endtask

    // ragged rows change the vector element within a row
    task automatic push_matrix(input int rows, input int cols, input bit ragged);
        t_mac_item it;
        for (int r = 0; r < rows; r++) begin
            it.vec = pick_q15();
            for (int c = 0; c < cols; c++) begin
                if (ragged)
                    it.vec = pick_q15();
                it.mat = pick_q15();
                item_queue.push_back(it);
            end
        end
    endtask

    // returns once nothing is queued, in flight or due
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_QUIET) begin
            @(negedge i_clk);
            if (item_queue.size() != 0 || feed_busy || dots_due.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ROW_TOTAL)
            rows_reg = data;
        else if (idx == CFG_COLUMN_TOTAL)
            cols_reg = data[COLTOT_W-1:0];
        regs_written++;
    endtask

    // input side: one transfer per accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                accumulate_item(feed_item.vec, feed_item.mat);
                items_accepted++;
                feed_busy = 1'b0;
            end
            if (!feed_busy && item_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                feed_item = item_queue.pop_front();
                feed_busy = 1'b1;
            end
        end
        i_in_valid     <= feed_busy;
        i_vector_value <= feed_item.vec;
        i_matrix_value <= feed_item.mat;
    end

    // result side
    always @(posedge i_clk) begin
        t_dot_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            dots_checked++;
            if (dots_due.size() == 0) begin
                err_count++;
                if (err_count <= PRINT_CAP)
                    $display("%0t: unexpected result col=%0d dot=%0d last=%0b", $time,
                             o_column_index, o_dot_value, o_last_output);
            end else begin
                want = dots_due.pop_front();
                if (o_column_index !== want.column || o_dot_value !== want.dot ||
                    o_last_output !== want.last) begin
                    err_count++;
                    if (err_count <= PRINT_CAP)
                        $display({"%0t: expected col=%0d dot=%0d last=%0b, ",
                                  "got col=%0d dot=%0d last=%0b"},
                                 $time, want.column, $signed(want.dot), want.last,
                                 o_column_index, o_dot_value, o_last_output);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     dots_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int rows;
        int cols;
        int nmat;
        int phase_items;
        logic [CFG_DAT_W-1:0] row_data;
        logic [CFG_DAT_W-1:0] col_data;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: one row, one column; product extremes
        push_item(Q_MAX, Q_MAX);
        push_item(Q_MIN, Q_MIN);
        push_item(Q_MIN, Q_MAX);
        push_item('0, -16'sd1);
        push_item(-16'sd1, -16'sd1);
        wait_drained();

        // zero sizes act as one; unused indexes are ignored
        write_reg(CFG_ROW_TOTAL, 16'd0);
        write_reg(CFG_COLUMN_TOTAL, 16'd0);
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'hA5A5);
        push_item(16'sd1, Q_MIN);
        wait_drained();

        // full-scale accumulation over three rows
        write_reg(CFG_ROW_TOTAL, 16'd3);
        write_reg(CFG_COLUMN_TOTAL, 16'd2);
        push_item(Q_MIN, Q_MIN);
        push_item(Q_MIN, Q_MAX);
        push_item(Q_MAX, Q_MAX);
        push_item(Q_MAX, Q_MIN);
        push_item(Q_MIN, Q_MIN);
        push_item(Q_MIN, Q_MIN);
        wait_drained();

        // largest row count, then cut short mid-matrix: row 2 becomes the last
        write_reg(CFG_ROW_TOTAL, 16'hFFFF);
        push_item(Q_MIN, Q_MIN);
        push_item(Q_MIN, Q_MAX);
        push_item(Q_MAX, Q_MIN);
        push_item(Q_MAX, 16'sh1234);
        wait_drained();
        write_reg(CFG_ROW_TOTAL, 16'd3);
        push_item(-16'sd2, Q_MIN);
        push_item(16'sh5555, -16'sh2AAA);
        wait_drained();

        // largest column count, then shrunk mid-row: position past the end counts as the last column
        write_reg(CFG_ROW_TOTAL, 16'd1);
        write_reg(CFG_COLUMN_TOTAL, 16'd1024);
        push_item(16'sd3, 16'sd7);
        push_item(Q_MIN, 16'sd1);
        push_item(16'sd1, Q_MAX);
        push_item(-16'sd5, -16'sd9);
        wait_drained();
        write_reg(CFG_COLUMN_TOTAL, 16'd3);
        push_item(Q_MAX, -16'sd1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (ph == 0) begin
                // column count above capacity saturates at MAX_COLUMNS
                write_reg(CFG_ROW_TOTAL, 16'd1);
                write_reg(CFG_COLUMN_TOTAL, 16'hFFFF);
                push_matrix(1, MAX_COLS, 1'b0);
                wait_drained();
            end
            phase_items = 0;
            while (phase_items < 35) begin
                rows = ($urandom_range(3) == 0) ? $urandom_range(2, 10) : $urandom_range(1, 4);
                cols = ($urandom_range(3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                row_data = CFG_DAT_W'(rows);
                col_data = CFG_DAT_W'(cols);
                if (rows == 1 && $urandom_range(1))
                    row_data = '0;
                if (cols == 1 && $urandom_range(1))
                    col_data = '0;
                if ($urandom_range(3) == 0)
                    col_data[CFG_DAT_W-1:COLTOT_W] = (CFG_DAT_W-COLTOT_W)'($urandom);
                write_reg(CFG_ROW_TOTAL, row_data);
                write_reg(CFG_COLUMN_TOTAL, col_data);
                nmat = (rows * cols > 48) ? 1 : $urandom_range(1, 3);
                for (int m = 0; m < nmat; m++)
                    push_matrix(rows, cols, $urandom_range(7) == 0);
                phase_items += nmat * rows * cols;
                wait_drained();
            end
        end

        wait_drained();
        $display("Streamed %0d matrix elements across %0d register writes;", items_accepted,
                 regs_written);
        $display("compared %0d dot products under four handshake pacing profiles.",
                 dots_checked);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
